/* sv/tkd_pkg.sv */
package tkd_pkg;

	// field widths
	localparam int KEY_W  = 5;
	localparam int BYTE_W = 8;
	localparam int CFG_W  = 12;

	// register reset and default queue depth, in key pairs
	localparam logic [CFG_W-1:0] SUBNEG_LIMIT_RESET = 12'd256;
	localparam int QUEUE_DEPTH = 2;

	typedef logic [KEY_W-1:0] key_t;

	// key codes
	localparam key_t KEY_ESC   = 5'd0;
	localparam key_t KEY_QUIT  = 5'd5;
	localparam key_t KEY_PLUS  = 5'd6;
	localparam key_t KEY_MINUS = 5'd7;
	localparam key_t KEY_TAB   = 5'd8;
	localparam key_t KEY_SPACE = 5'd9;
	localparam key_t KEY_ENTER = 5'd10;
	localparam key_t KEY_LIST  = 5'd11;
	localparam key_t KEY_HELP  = 5'd12;
	localparam key_t KEY_DIG1  = 5'd13;
	localparam key_t KEY_DIG2  = 5'd14;
	localparam key_t KEY_DIG3  = 5'd15;
	localparam key_t KEY_DIG4  = 5'd16;

	// one or two keys caused by a single input transaction
	typedef struct packed {
		logic valid;
		logic two;
		key_t key0;
		key_t key1;
	} key_pair_t;

endpackage

/* sv/tkd_parser.sv */
module tkd_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        in_action,
	input  logic [tkd_pkg::BYTE_W-1:0]  in_byte,
	input  logic                        cfg_we,
	input  logic [tkd_pkg::CFG_W-1:0]   cfg_limit,
	input  logic                        push_ready,
	output tkd_pkg::key_pair_t          push
);

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_IAC     = 3'd1,
		ST_IAC_OPT = 3'd2,
		ST_SB      = 3'd3,
		ST_SB_IAC  = 3'd4,
		ST_ESC     = 3'd5,
		ST_ESC_SEQ = 3'd6
	} state_t;

	localparam logic [7:0] B_IAC  = 8'hff;
	localparam logic [7:0] B_SB   = 8'hfa;
	localparam logic [7:0] B_SE   = 8'hf0;
	localparam logic [7:0] B_WILL = 8'd251;
	localparam logic [7:0] B_DONT = 8'd254;
	localparam logic [7:0] B_ESC  = 8'd27;
	localparam logic [7:0] B_CSI  = 8'h5b;
	localparam logic [7:0] B_SS3  = 8'h4f;
	localparam logic [7:0] B_UPA  = 8'h41;
	localparam logic [7:0] B_UPD  = 8'h44;
	localparam logic [7:0] B_ARROW_BASE = 8'h40;

	// plain byte to key map
	function automatic logic [tkd_pkg::KEY_W:0] plain_key(input logic [7:0] b);
		logic [tkd_pkg::KEY_W:0] r;
		r = '0;
		unique case (b)
			8'h71, 8'h51: r = {1'b1, tkd_pkg::KEY_QUIT};
			8'h2b:        r = {1'b1, tkd_pkg::KEY_PLUS};
			8'h2d:        r = {1'b1, tkd_pkg::KEY_MINUS};
			8'h09:        r = {1'b1, tkd_pkg::KEY_TAB};
			8'h20:        r = {1'b1, tkd_pkg::KEY_SPACE};
			8'h0d, 8'h0a: r = {1'b1, tkd_pkg::KEY_ENTER};
			8'h6c, 8'h4c: r = {1'b1, tkd_pkg::KEY_LIST};
			8'h68, 8'h48: r = {1'b1, tkd_pkg::KEY_HELP};
			8'h31:        r = {1'b1, tkd_pkg::KEY_DIG1};
			8'h32:        r = {1'b1, tkd_pkg::KEY_DIG2};
			8'h33:        r = {1'b1, tkd_pkg::KEY_DIG3};
			8'h34:        r = {1'b1, tkd_pkg::KEY_DIG4};
			default:      r = '0;
		endcase
		return r;
	endfunction

	logic                        valid_s1;
	logic                        action_s1;
	logic [7:0]                  byte_s1;
	logic [tkd_pkg::CFG_W-1:0]   limit_q;
	state_t                      state_q, state_d;
	logic [tkd_pkg::CFG_W-1:0]   count_q, count_d;
	logic                        consume;
	logic [tkd_pkg::KEY_W:0]     ib_key;
	state_t                      ib_state;
	logic [tkd_pkg::CFG_W:0]     grow_c;
	logic                        grow_drop;
	state_t                      grow_state;
	tkd_pkg::key_pair_t          res;

	assign consume  = valid_s1 && push_ready;
	assign in_ready = !valid_s1 || consume;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1 <= in_action;
			byte_s1   <= in_byte;
		end
	end

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= tkd_pkg::SUBNEG_LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_limit;
		end
	end

	// byte as seen from idle
	always_comb begin
		ib_key = plain_key(byte_s1);
		if (byte_s1 == B_IAC) begin
			ib_state = ST_IAC;
		end else if (byte_s1 == B_ESC) begin
			ib_state = ST_ESC;
		end else begin
			ib_state = ST_IDLE;
		end
	end

	// subnegotiation growth; the sb byte itself counts from one
	always_comb begin
		grow_c     = ((state_q == ST_IAC) ? {{tkd_pkg::CFG_W{1'b0}}, 1'b1} : {1'b0, count_q})
		             + {{tkd_pkg::CFG_W{1'b0}}, 1'b1};
		grow_drop  = grow_c > {1'b0, limit_q};
		grow_state = (byte_s1 == B_IAC) ? ST_SB_IAC : ST_SB;
	end

	// next state and keys
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		res      = '0;
		res.key0 = tkd_pkg::KEY_ESC;
		res.key1 = tkd_pkg::KEY_ESC;
		if (action_s1) begin
			if (state_q == ST_ESC || state_q == ST_ESC_SEQ) begin
				state_d   = ST_IDLE;
				res.valid = 1'b1;
			end
		end else begin
			unique case (state_q)
				ST_IAC: begin
					if (byte_s1 == B_SB) begin
						if (grow_drop) begin
							state_d = ST_IDLE;
							count_d = '0;
						end else begin
							state_d = ST_SB;
							count_d = grow_c[tkd_pkg::CFG_W-1:0];
						end
					end else if (byte_s1 >= B_WILL && byte_s1 <= B_DONT) begin
						state_d = ST_IAC_OPT;
					end else begin
						state_d = ST_IDLE;
					end
				end
				ST_IAC_OPT: begin
					state_d = ST_IDLE;
				end
				ST_SB, ST_SB_IAC: begin
					if (state_q == ST_SB_IAC && byte_s1 == B_SE) begin
						state_d = ST_IDLE;
						count_d = '0;
					end else if (grow_drop) begin
						state_d = ST_IDLE;
						count_d = '0;
					end else begin
						state_d = grow_state;
						count_d = grow_c[tkd_pkg::CFG_W-1:0];
					end
				end
				ST_ESC, ST_ESC_SEQ: begin
					if (state_q == ST_ESC && (byte_s1 == B_CSI || byte_s1 == B_SS3)) begin
						state_d = ST_ESC_SEQ;
					end else if (state_q == ST_ESC_SEQ && byte_s1 >= B_UPA
					             && byte_s1 <= B_UPD) begin
						state_d   = ST_IDLE;
						res.valid = 1'b1;
						res.key0  = tkd_pkg::KEY_W'(byte_s1 - B_ARROW_BASE);
					end else begin
						// broken escape, then the byte again from idle
						state_d   = ib_state;
						res.valid = 1'b1;
						res.two   = ib_key[tkd_pkg::KEY_W];
						res.key1  = ib_key[tkd_pkg::KEY_W-1:0];
					end
				end
				default: begin
					state_d   = ib_state;
					count_d   = '0;
					res.valid = ib_key[tkd_pkg::KEY_W];
					res.key0  = ib_key[tkd_pkg::KEY_W-1:0];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else if (consume) begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	assign push = consume ? res : '0;

	// a pair of keys always starts with the escape of a broken sequence
	a_pair_esc: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && push.two) |-> (push.key0 == tkd_pkg::KEY_ESC))
		else $error("two keys without leading escape");

	// a flush outside an escape leaves the state alone
	a_flush_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && action_s1 && state_q != ST_ESC && state_q != ST_ESC_SEQ)
		|=> (state_q == $past(state_q) && count_q == $past(count_q)))
		else $error("flush changed parser state");

endmodule

/* sv/tkd_key_queue.sv */
module tkd_key_queue #(
	parameter int DEPTH = tkd_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tkd_pkg::key_pair_t  push,
	output logic                push_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output tkd_pkg::key_t       out_key,
	output logic                out_last
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tkd_pkg::key_pair_t  mem_q [DEPTH];
	logic [AW-1:0]       wptr_q, rptr_q;
	logic [CW-1:0]       count_q;
	logic                half_q;
	tkd_pkg::key_pair_t  head;
	logic                out_fire, pop, wr;

	assign head       = mem_q[rptr_q];
	assign push_ready = count_q != CW'(DEPTH);
	assign out_valid  = count_q != '0;
	assign out_key    = half_q ? head.key1 : head.key0;
	assign out_last   = !head.two || half_q;
	assign out_fire   = out_valid && out_ready;
	assign pop        = out_fire && out_last;
	assign wr         = push.valid && push_ready;

	// pair storage
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= push;
		end
	end

	// pointers, fill count and second-key flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
			half_q  <= 1'b0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (wr && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !wr) begin
				count_q <= count_q - CW'(1);
			end
			if (out_fire) begin
				half_q <= !out_last;
			end
		end
	end

	a_half_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> (count_q != '0 && head.two))
		else $error("second key pending on empty or single entry");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == CW'(DEPTH) && !pop) |=> (count_q == CW'(DEPTH)))
		else $error("queue count left full without a pop");

endmodule

/* sv/terminal_key_decoder_core.sv */
// the input byte is registered at the parser; its keys then go through the pair queue
// throughput: one input transaction per cycle while the pair queue has room; an item
//   that yields two keys takes two output transfers, the pair queue absorbs the rest
// reset: arst_n asynchronous, active low; parser back to idle, count zero,
//   subneg_limit back to 256, key queue empty
module terminal_key_decoder_core #(
	parameter int QUEUE_DEPTH = tkd_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [7:0]                 s_axis_tdata,   // [7:0] data_byte
	input  logic [0:0]                 s_axis_tuser,   // [0] action
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [7:0]                 m_axis_tdata,   // [4:0] key, [7:5] zero
	output logic                       m_axis_tlast,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [tkd_pkg::CFG_W-1:0]  cfg_data
);

	tkd_pkg::key_pair_t push;
	logic               push_ready;
	tkd_pkg::key_t      out_key;

	assign cfg_ready = 1'b1;

	tkd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_action  (s_axis_tuser[0]),
		.in_byte    (s_axis_tdata),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_limit  (cfg_data),
		.push_ready (push_ready),
		.push       (push)
	);

	tkd_key_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_key    (out_key),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {{(8 - tkd_pkg::KEY_W){1'b0}}, out_key};

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	// telnet and terminal byte values
	localparam logic [7:0] BYTE_IAC  = 8'hff;
	localparam logic [7:0] BYTE_SB   = 8'hfa;
	localparam logic [7:0] BYTE_SE   = 8'hf0;
	localparam logic [7:0] BYTE_WILL = 8'd251;
	localparam logic [7:0] BYTE_DONT = 8'd254;
	localparam logic [7:0] BYTE_ESC  = 8'd27;
	localparam logic [7:0] BYTE_TAB  = 8'h09;
	localparam logic [7:0] BYTE_CR   = 8'h0d;
	localparam logic [7:0] BYTE_LF   = 8'h0a;
	localparam tkd_pkg::key_t ARROW_UP = 5'd1;

	// input actions
	localparam bit ACT_FEED  = 1'b0;
	localparam bit ACT_FLUSH = 1'b1;

	typedef enum logic [2:0] {
		PS_IDLE, PS_IAC, PS_IAC_OPT, PS_SB, PS_SB_IAC, PS_ESC, PS_ESC_SEQ
	} parse_state_t;

	typedef struct {
		tkd_pkg::key_t key;
		bit            last;
	} key_result_t;

	// tracks the decoder state and holds the keys still to come out
	class key_decode_board_t;
		key_result_t    keys_due[$];
		tkd_pkg::key_t  keys_now[$];
		parse_state_t   state;
		int unsigned    count;
		int unsigned    limit;
		int             errors;

		function new();
			state  = PS_IDLE;
			count  = 0;
			limit  = tkd_pkg::SUBNEG_LIMIT_RESET;
			errors = 0;
		endfunction

		function void set_limit(logic [tkd_pkg::CFG_W-1:0] value);
			limit = value;
		endfunction

		function int outstanding();
			return keys_due.size();
		endfunction

		function void emit(tkd_pkg::key_t k);
			if (keys_now.size() < 2)
				keys_now.push_back(k);
		endfunction

		// one more subnegotiation byte, abandoned once past the limit
		function void grow(parse_state_t next_state);
			int unsigned c;
			c = count + 1;
			if (c > limit) begin
				state = PS_IDLE;
				count = 0;
			end else begin
				state = next_state;
				count = c & 12'hfff;
			end
		endfunction

		function void idle_byte(logic [7:0] b);
			if (b == BYTE_IAC) begin
				state = PS_IAC;
			end else if (b == BYTE_ESC) begin
				state = PS_ESC;
			end else begin
				case (b)
					"q", "Q":       emit(tkd_pkg::KEY_QUIT);
					"+":            emit(tkd_pkg::KEY_PLUS);
					"-":            emit(tkd_pkg::KEY_MINUS);
					BYTE_TAB:       emit(tkd_pkg::KEY_TAB);
					" ":            emit(tkd_pkg::KEY_SPACE);
					BYTE_CR, BYTE_LF: emit(tkd_pkg::KEY_ENTER);
					"l", "L":       emit(tkd_pkg::KEY_LIST);
					"h", "H":       emit(tkd_pkg::KEY_HELP);
					"1":            emit(tkd_pkg::KEY_DIG1);
					"2":            emit(tkd_pkg::KEY_DIG2);
					"3":            emit(tkd_pkg::KEY_DIG3);
					"4":            emit(tkd_pkg::KEY_DIG4);
					default:        ;
				endcase
			end
		endfunction

		// accepted input transaction: advance the parser, queue its keys
		function void note_byte(bit act, logic [7:0] b);
			key_result_t r;
			keys_now.delete();
			if (act == ACT_FLUSH) begin
				if (state == PS_ESC || state == PS_ESC_SEQ) begin
					state = PS_IDLE;
					emit(tkd_pkg::KEY_ESC);
				end
			end else begin
				case (state)
					PS_IAC: begin
						if (b == BYTE_SB) begin
							count = 1;
							grow(PS_SB);
						end else if (b >= BYTE_WILL && b <= BYTE_DONT) begin
							state = PS_IAC_OPT;
						end else begin
							state = PS_IDLE;
						end
					end
					PS_IAC_OPT: state = PS_IDLE;
					PS_SB: grow(b == BYTE_IAC ? PS_SB_IAC : PS_SB);
					PS_SB_IAC: begin
						if (b == BYTE_SE) begin
							state = PS_IDLE;
							count = 0;
						end else begin
							grow(b == BYTE_IAC ? PS_SB_IAC : PS_SB);
						end
					end
					PS_ESC: begin
						if (b == "[" || b == "O") begin
							state = PS_ESC_SEQ;
						end else begin
							state = PS_IDLE;
							emit(tkd_pkg::KEY_ESC);
							idle_byte(b);
						end
					end
					PS_ESC_SEQ: begin
						state = PS_IDLE;
						if (b >= "A" && b <= "D") begin
							emit(ARROW_UP + tkd_pkg::key_t'(b - "A"));
						end else begin
							emit(tkd_pkg::KEY_ESC);
							idle_byte(b);
						end
					end
					default: begin
						state = PS_IDLE;
						count = 0;
						idle_byte(b);
					end
				endcase
			end
			foreach (keys_now[i]) begin
				r.key  = keys_now[i];
				r.last = (i == keys_now.size() - 1);
				keys_due.push_back(r);
			end
		endfunction

		// accepted output transaction against the oldest expected key
		function void check_key(tkd_pkg::key_t k, bit l);
			key_result_t r;
			if (keys_due.size() == 0) begin
				$error("key %0d last %0d arrived with nothing expected", k, l);
				errors++;
			end else begin
				r = keys_due.pop_front();
				if (k !== r.key) begin
					$error("key mismatch: expected %0d, actual %0d", r.key, k);
					errors++;
				end
				if (l !== r.last) begin
					$error("last mismatch: expected %0d, actual %0d", r.last, l);
					errors++;
				end
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [7:0]                s_axis_tdata = '0;   // [7:0] data_byte
	logic [0:0]                s_axis_tuser = '0;   // [0] action
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [7:0]                m_axis_tdata;        // [4:0] key, [7:5] zero
	logic                      m_axis_tlast;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [tkd_pkg::CFG_W-1:0] cfg_data = '0;

	key_decode_board_t keys = new();
	bit quiet = 1'b0;       // no idling on either side
	bit hold_req = 1'b0;    // receiver holds off for a long stretch
	int unsigned bytes_sent = 0;
	logic [7:0] plain_set [16] = '{"q", "Q", "+", "-", BYTE_TAB, " ", BYTE_CR, BYTE_LF,
		"l", "L", "h", "H", "1", "2", "3", "4"};

	terminal_key_decoder_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// overall time limit
	initial begin
		#3000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (80) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				m_axis_tready <= quiet || ($urandom_range(99) >= 15);
			end
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			keys.check_key(m_axis_tdata[tkd_pkg::KEY_W-1:0], m_axis_tlast);
	end

	// one input transaction, with random idle cycles ahead of it
	task automatic send_item(bit act, logic [7:0] b);
		while (!quiet && $urandom_range(99) < 15) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		keys.note_byte(act, b);
		bytes_sent++;
		@(negedge clk);
	endtask

	// stop sending and wait until every expected key is out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (keys.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_limit(logic [tkd_pkg::CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		keys.set_limit(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(255));
	endfunction

	// one random well-formed or broken sequence
	task automatic send_random_group();
		int kind;
		int len;
		kind = $urandom_range(99);
		if (kind < 30) begin
			send_item(ACT_FEED, plain_set[$urandom_range(15)]);
		end else if (kind < 45) begin
			send_item(ACT_FEED, BYTE_ESC);
			send_item(ACT_FEED, $urandom_range(1) ? "[" : "O");
			send_item(ACT_FEED, 8'("A" + $urandom_range(3)));
		end else if (kind < 53) begin
			send_item(ACT_FEED, BYTE_ESC);
			if ($urandom_range(1))
				send_item(ACT_FEED, $urandom_range(1) ? "[" : "O");
			send_item(ACT_FEED, $urandom_range(1) ? plain_set[$urandom_range(15)] : any_byte());
		end else if (kind < 62) begin
			send_item(ACT_FEED, BYTE_IAC);
			if ($urandom_range(1)) begin
				send_item(ACT_FEED, 8'(BYTE_WILL + $urandom_range(3)));
				send_item(ACT_FEED, any_byte());
			end else begin
				send_item(ACT_FEED, any_byte());
			end
		end else if (kind < 74) begin
			// subnegotiation, sometimes past the limit or left open
			send_item(ACT_FEED, BYTE_IAC);
			send_item(ACT_FEED, BYTE_SB);
			len = $urandom_range(keys.limit + 2 > 20 ? 20 : keys.limit + 2);
			repeat (len) begin
				if ($urandom_range(7) == 0) begin
					send_item(ACT_FEED, BYTE_IAC);
					send_item(ACT_FEED, BYTE_IAC);
				end else begin
					send_item(ACT_FEED, any_byte());
				end
			end
			if ($urandom_range(7) != 0) begin
				send_item(ACT_FEED, BYTE_IAC);
				send_item(ACT_FEED, BYTE_SE);
			end
		end else if (kind < 82) begin
			if ($urandom_range(3) != 0) begin
				send_item(ACT_FEED, BYTE_ESC);
				if ($urandom_range(1))
					send_item(ACT_FEED, $urandom_range(1) ? "[" : "O");
			end
			send_item(ACT_FLUSH, any_byte());
		end else begin
			send_item($urandom_range(3) == 0 ? ACT_FLUSH : ACT_FEED, any_byte());
		end
	endtask

	task automatic random_phase(int unsigned n);
		int unsigned stop_at;
		stop_at = bytes_sent + n;
		while (bytes_sent < stop_at) send_random_group();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: arrows, broken escapes, flushes, telnet commands
		send_item(ACT_FEED, BYTE_ESC);
		send_item(ACT_FEED, "[");
		send_item(ACT_FEED, "A");
		send_item(ACT_FEED, BYTE_ESC);
		send_item(ACT_FEED, "O");
		send_item(ACT_FEED, "D");
		send_item(ACT_FEED, BYTE_ESC);
		send_item(ACT_FEED, "q");
		send_item(ACT_FEED, BYTE_ESC);
		send_item(ACT_FEED, "[");
		send_item(ACT_FEED, "1");
		send_item(ACT_FLUSH, 8'hff);
		send_item(ACT_FEED, BYTE_ESC);
		send_item(ACT_FLUSH, 8'h00);
		send_item(ACT_FEED, BYTE_IAC);
		send_item(ACT_FEED, BYTE_IAC);
		send_item(ACT_FEED, BYTE_IAC);
		send_item(ACT_FEED, BYTE_WILL);
		send_item(ACT_FEED, 8'd5);
		send_item(ACT_FEED, BYTE_IAC);
		send_item(ACT_FEED, BYTE_SB);
		send_item(ACT_FEED, 8'd7);
		send_item(ACT_FEED, BYTE_IAC);
		send_item(ACT_FEED, BYTE_IAC);
		send_item(ACT_FEED, BYTE_SE);
		send_item(ACT_FEED, 8'h00);
		drain();

		// smallest limit: an open subnegotiation is dropped quickly
		write_limit(12'd3);
		send_item(ACT_FEED, BYTE_IAC);
		send_item(ACT_FEED, BYTE_SB);
		send_item(ACT_FEED, "1");
		send_item(ACT_FEED, "2");
		send_item(ACT_FEED, "3");
		random_phase(200);
		drain();

		// largest limit, no idling anywhere
		write_limit(12'd4095);
		quiet = 1'b1;
		random_phase(200);
		drain();
		quiet = 1'b0;

		// receiver holds off while the sender keeps going
		write_limit(12'd17);
		hold_req = 1'b1;
		random_phase(200);
		drain();

		// sender pauses mid-phase until every key is out
		write_limit(tkd_pkg::SUBNEG_LIMIT_RESET);
		random_phase(100);
		drain();
		random_phase(100);
		drain();

		write_limit(12'($urandom_range(3, 40)));
		random_phase(200);
		drain();

		write_limit(12'($urandom_range(3, 4095)));
		random_phase(200);
		drain();

		repeat (10) @(posedge clk);
		if (keys.errors == 0 && keys.outstanding() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
